// ===== design/plt_pkg.sv =====
// Shared types and constants of the peer liveness table.
package plt_pkg;

  // Result codes carried in event_res.
  typedef enum logic [1:0] {
    EV_NEW     = 2'd0,
    EV_EXPIRED = 2'd1,
    EV_FULL    = 2'd2,
    EV_NONE    = 2'd3
  } ev_t;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = CFG_IDX_W'(1);
  localparam logic [31:0] SWEEP_PERIOD_RST = 32'd1000;
  localparam logic [31:0] IDLE_LIMIT_RST   = 32'd3000;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen;
  } slot_word_t;

  localparam int unsigned SLOT_W = $bits(slot_word_t);

endpackage

// ===== design/plt_hb_if.sv =====
// Heartbeat input channel of the peer liveness table.
interface plt_hb_if;
  logic        valid;
  logic        ready;
  logic [31:0] peer_addr;
  logic [15:0] peer_port;
  logic [31:0] now_ms;

  modport source(output valid, peer_addr, peer_port, now_ms, input ready);
  modport sink(input valid, peer_addr, peer_port, now_ms, output ready);
endinterface

// ===== design/plt_ev_if.sv =====
// Event result channel of the peer liveness table.
interface plt_ev_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [31:0] event_addr;
  logic [15:0] event_port;
  logic        last_of_run;

  modport source(output valid, event_res, event_addr, event_port, last_of_run,
                 input ready);
  modport sink(input valid, event_res, event_addr, event_port, last_of_run,
               output ready);
endinterface

// ===== design/plt_cfg_if.sv =====
// Configuration write channel of the peer liveness table.
interface plt_cfg_if
  import plt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/plt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module plt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/peer_liveness_table.sv =====
// Peer liveness table: heartbeat lookup, insertion and timed expiry over a slot memory.
//
// After reset the block clears its slot memory, one entry a cycle, and
// takes no heartbeat until that pass is over; configuration writes are
// taken at any time. Each heartbeat then walks the table once through the
// single read port of the slot memory to find its entry or the lowest free
// slot, writes the entry back when it was found or a slot is free, and, when
// a sweep is due, walks the table a second time to remove idle entries. A
// heartbeat holds the block longer when it triggers a sweep, and while the
// event channel holds off a transfer. Events leave through an output
// register, so a finished event may wait there while work goes on.
module peer_liveness_table
  import plt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input logic     clk,
  input logic     rst,
  plt_hb_if.sink  hb,
  plt_ev_if.source ev,
  plt_cfg_if.sink cfg
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CLR_LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_UPD   = 6'b001000,
    ST_SWEEP = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;

  // Configuration and sweep timing.
  logic [31:0] sweep_period;
  logic [31:0] idle_limit;
  logic [31:0] last_sweep;

  // Heartbeat being worked on.
  logic [31:0] hb_addr;
  logic [15:0] hb_port;
  logic [31:0] hb_now;

  // Table walk: issue counter and evaluation stage.
  logic [CW-1:0] r_idx;
  logic          e_v;
  logic [IW-1:0] e_idx;
  logic          hit_f;
  logic [IW-1:0] hit_idx;
  logic          free_f;
  logic [IW-1:0] free_idx;

  // Held-back event and output register.
  logic        pend_v;
  ev_t         pend_res;
  logic [31:0] pend_addr;
  logic [15:0] pend_port;
  logic        o_valid;
  ev_t         o_res;
  logic [31:0] o_addr;
  logic [15:0] o_port;
  logic        o_last;

  // Slot memory ports.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  slot_word_t        ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_rdata;
  slot_word_t        word;

  logic        r_done;
  logic        match;
  logic [31:0] age;
  logic [31:0] since;
  logic        expire;
  logic        sweep_due;
  logic        out_free;
  logic        can_push;
  logic        stall;
  logic        o_push;

  plt_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(r_idx[IW-1:0]),
    .rdata(ram_rdata)
  );

  // Decode of the entry under evaluation.
  assign word      = slot_word_t'(ram_rdata);
  assign r_done    = (r_idx == CNT_END);
  assign match     = (word.addr == hb_addr) && (word.port == hb_port);
  assign age       = hb_now - word.seen;
  assign since     = hb_now - last_sweep;
  assign expire    = word.valid && (age >= idle_limit);
  assign sweep_due = (since >= sweep_period);
  assign out_free  = !o_valid || ev.ready;
  assign can_push  = !pend_v || out_free;
  assign stall     = e_v && expire && !can_push;

  // The output register is loaded when an event moves out of the holding slot, and when the run closes.
  assign o_push = ((state == ST_SWEEP) && !stall && e_v && expire && pend_v) ||
                  ((state == ST_FIN) && out_free);

  // Handshake and payload outputs.
  assign hb.ready       = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign ev.valid       = o_valid;
  assign ev.event_res   = o_res;
  assign ev.event_addr  = o_addr;
  assign ev.event_port  = o_port;
  assign ev.last_of_run = o_last;

  // Slot memory control for each phase.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = e_idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = r_idx[IW-1:0];
      end
      ST_LOOK: begin
        ram_re = !r_done;
      end
      ST_UPD: begin
        ram_we    = hit_f || free_f;
        ram_waddr = hit_f ? hit_idx : free_idx;
        ram_wdata = '{valid: 1'b1, addr: hb_addr, port: hb_port, seen: hb_now};
      end
      ST_SWEEP: begin
        ram_re = !stall && !r_done;
        ram_we = e_v && expire && !stall;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_period <= SWEEP_PERIOD_RST;
      idle_limit   <= IDLE_LIMIT_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_SWEEP_PERIOD) begin
        sweep_period <= cfg.data;
      end else if (cfg.index == CFG_IDLE_LIMIT) begin
        idle_limit <= cfg.data;
      end
    end
  end

  // Output register occupancy: filled on a load, emptied on a completed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_push) begin
      o_valid <= 1'b1;
    end else if (ev.ready) begin
      o_valid <= 1'b0;
    end
  end

  // Heartbeat sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      r_idx      <= '0;
      e_v        <= 1'b0;
      pend_v     <= 1'b0;
      last_sweep <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          r_idx <= r_idx + CW'(1);
          if (r_idx == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (hb.valid) begin
            hb_addr <= hb.peer_addr;
            hb_port <= hb.peer_port;
            hb_now  <= hb.now_ms;
            r_idx   <= '0;
            e_v     <= 1'b0;
            hit_f   <= 1'b0;
            free_f  <= 1'b0;
            state   <= ST_LOOK;
          end
        end

        // Find the first matching valid entry and the lowest free slot.
        ST_LOOK: begin
          e_v   <= !r_done;
          e_idx <= r_idx[IW-1:0];
          if (!r_done) begin
            r_idx <= r_idx + CW'(1);
          end
          if (e_v) begin
            if (word.valid) begin
              if (match && !hit_f) begin
                hit_f   <= 1'b1;
                hit_idx <= e_idx;
              end
            end else if (!free_f) begin
              free_f   <= 1'b1;
              free_idx <= e_idx;
            end
            if (e_idx == IDX_LAST) begin
              state <= ST_UPD;
            end
          end
        end

        // Refresh or insert the entry and queue the new or full event.
        ST_UPD: begin
          if (!hit_f) begin
            pend_v    <= 1'b1;
            pend_res  <= free_f ? EV_NEW : EV_FULL;
            pend_addr <= hb_addr;
            pend_port <= hb_port;
          end
          r_idx <= '0;
          e_v   <= 1'b0;
          if (sweep_due) begin
            last_sweep <= hb_now;
            state      <= ST_SWEEP;
          end else begin
            state <= ST_FIN;
          end
        end

        // Remove idle entries in slot order, holding while events back up.
        ST_SWEEP: begin
          if (!stall) begin
            if (e_v && expire) begin
              if (pend_v) begin
                o_res  <= pend_res;
                o_addr <= pend_addr;
                o_port <= pend_port;
                o_last <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_res  <= EV_EXPIRED;
              pend_addr <= word.addr;
              pend_port <= word.port;
            end
            e_v   <= !r_done;
            e_idx <= r_idx[IW-1:0];
            if (r_done) begin
              state <= ST_FIN;
            end else begin
              r_idx <= r_idx + CW'(1);
            end
          end
        end

        // Close the run with the held event, or a quiet result.
        ST_FIN: begin
          if (out_free) begin
            o_last <= 1'b1;
            if (pend_v) begin
              o_res  <= pend_res;
              o_addr <= pend_addr;
              o_port <= pend_port;
            end else begin
              o_res  <= EV_NONE;
              o_addr <= '0;
              o_port <= '0;
            end
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
